>>> rtl/rspi_pkg.sv
// Shared types, widths and codes for the ray/sphere/plane intersection pipeline.
// No dependencies; every other rtl file imports this package.
package rspi_pkg;

	localparam int DIR_FRAC_BITS = 14;

	localparam int CRD_W  = 32;
	localparam int DIR_W  = 16;
	localparam int RAD_W  = 31;
	localparam int DIST_W = 32;

	localparam int LD_W  = CRD_W + DIR_W;           // coord * unit product
	localparam int SUM_W = LD_W + 2;                // sum of three products
	localparam int UB_W  = LD_W;                    // |dot(coord, unit)|
	localparam int LL_W  = 2 * CRD_W;               // |L|^2
	localparam int RR_W  = 2 * RAD_W;               // r^2
	localparam int DN_W  = 2 * DIR_W;               // unit * unit product
	localparam int DA_W  = DN_W + 2;
	localparam int UA_W  = DN_W;                    // |d.n|
	localparam int LO_W  = UB_W / 2;                // low half of B for B^2
	localparam int HI_W  = UB_W - LO_W;
	localparam int LHS_W = LL_W + 2 * DIR_FRAC_BITS;
	localparam int BB_W  = 2 * UB_W;
	localparam int Q_W   = ((LHS_W > BB_W) ? LHS_W : BB_W) + 1;
	localparam int SQ_W  = (Q_W + 1) / 2;           // root bits, one per stage
	localparam int RD_W  = 2 * SQ_W;                // radicand, padded to even
	localparam int T_W   = ((UB_W > SQ_W) ? UB_W : SQ_W) + 1;
	localparam int NUM_W = UB_W + DIR_FRAC_BITS;    // plane dividend
	localparam int QB    = DIST_W;                  // quotient bits, one per stage
	localparam int DR_W  = (NUM_W > UA_W + QB) ? NUM_W : UA_W + QB;
	localparam int PAD   = SQ_W - QB;               // divider delay to match sqrt

	localparam logic [1:0] KIND_SPHERE = 2'd0;
	localparam logic [1:0] KIND_PLANE  = 2'd1;

	typedef enum logic [2:0] {
		CAUSE_HIT          = 3'd0,
		CAUSE_BEHIND       = 3'd1,
		CAUSE_NO_ROOT      = 3'd2,
		CAUSE_NONPOS       = 3'd3,
		CAUSE_PARALLEL     = 3'd4,
		CAUSE_PLANE_BEHIND = 3'd5,
		CAUSE_KIND         = 3'd6
	} cause_t;

	// travels alongside the sqrt stages
	typedef struct packed {
		logic            plane;
		logic            sat;
		cause_t          cause;
		logic [UB_W-1:0] b;
	} meta_t;

	typedef struct packed {
		logic [UA_W-1:0]  ua;
		logic [NUM_W-1:0] num;
	} div_req_t;

endpackage

>>> rtl/rspi_front.sv
// Front end: products, dot sums, B^2 and the discriminant, five register stages.
// Depends on rspi_pkg.
module rspi_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [1:0]                          kind,
	input  logic signed [rspi_pkg::CRD_W-1:0]   lv [3],
	input  logic signed [rspi_pkg::DIR_W-1:0]   dv [3],
	input  logic signed [rspi_pkg::DIR_W-1:0]   nv [3],
	input  logic [rspi_pkg::RAD_W-1:0]          radius,
	output logic                                out_vld,
	output rspi_pkg::meta_t                     meta,
	output logic [rspi_pkg::RD_W-1:0]           rad,
	output rspi_pkg::div_req_t                  dreq
);
	import rspi_pkg::*;

	logic [CRD_W-1:0] lmag [3];

	logic                    vld_s1;
	logic [1:0]              kind_s1;
	logic signed [LD_W-1:0]  ld_s1 [3];
	logic signed [LD_W-1:0]  ln_s1 [3];
	logic [LL_W-1:0]         ll_s1 [3];
	logic [RR_W-1:0]         rr_s1;
	logic signed [DN_W-1:0]  dn_s1 [3];

	logic                    vld_s2;
	logic [1:0]              kind_s2;
	logic signed [SUM_W-1:0] bs_s2;
	logic [LL_W-1:0]         l2_s2;
	logic [RR_W-1:0]         rr_s2;
	logic signed [DA_W-1:0]  da_s2;
	logic signed [SUM_W-1:0] db_s2;

	logic                    vld_s3;
	logic [UB_W-1:0]         b_s3;
	logic [2*HI_W-1:0]       hh_s3;
	logic [HI_W+LO_W-1:0]    hl_s3;
	logic [2*LO_W-1:0]       bl2_s3;
	logic [Q_W-1:0]          lhs_s3;
	logic [Q_W-1:0]          rr2_s3;
	cause_t                  cause_s3;
	logic                    plane_s3;
	logic [UA_W-1:0]         ua_s3;
	logic [NUM_W-1:0]        num_s3;
	cause_t                  cause_c3;

	logic                    vld_s4;
	logic [UB_W-1:0]         b_s4;
	logic [Q_W-1:0]          rhs_s4;
	logic [Q_W-1:0]          lhs_s4;
	cause_t                  cause_s4;
	logic                    plane_s4;
	logic                    sat_s4;
	logic [UA_W-1:0]         ua_s4;
	logic [NUM_W-1:0]        num_s4;

	logic [Q_W:0]            diff;
	logic                    vld_s5;
	meta_t                   meta_s5;
	logic [RD_W-1:0]         rad_s5;
	div_req_t                dreq_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lmag[i] = lv[i][CRD_W-1] ? CRD_W'(-lv[i]) : CRD_W'(lv[i]);
		end
	end

	always_comb begin
		priority if (kind_s2 == KIND_SPHERE) begin
			cause_c3 = (bs_s2 < 0) ? CAUSE_BEHIND : CAUSE_HIT;
		end else if (kind_s2 == KIND_PLANE) begin
			priority if (da_s2 == 0) begin
				cause_c3 = CAUSE_PARALLEL;
			end else if (db_s2 == 0 || ((da_s2 < 0) != (db_s2 < 0))) begin
				cause_c3 = CAUSE_PLANE_BEHIND;
			end else begin
				cause_c3 = CAUSE_HIT;
			end
		end else begin
			cause_c3 = CAUSE_KIND;
		end
	end

	assign diff = {1'b0, rhs_s4} - {1'b0, lhs_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// s1: all products
		kind_s1 <= kind;
		for (int i = 0; i < 3; i++) begin
			ld_s1[i] <= LD_W'(lv[i]) * LD_W'(dv[i]);
			ln_s1[i] <= LD_W'(lv[i]) * LD_W'(nv[i]);
			ll_s1[i] <= LL_W'(lmag[i]) * LL_W'(lmag[i]);
			dn_s1[i] <= DN_W'(dv[i]) * DN_W'(nv[i]);
		end
		rr_s1 <= RR_W'(radius) * RR_W'(radius);

		// s2: dot sums
		kind_s2 <= kind_s1;
		bs_s2   <= SUM_W'(ld_s1[0]) + SUM_W'(ld_s1[1]) + SUM_W'(ld_s1[2]);
		db_s2   <= SUM_W'(ln_s1[0]) + SUM_W'(ln_s1[1]) + SUM_W'(ln_s1[2]);
		da_s2   <= DA_W'(dn_s1[0]) + DA_W'(dn_s1[1]) + DA_W'(dn_s1[2]);
		l2_s2   <= ll_s1[0] + ll_s1[1] + ll_s1[2];
		rr_s2   <= rr_s1;

		// s3: B^2 partials, early causes, plane operands
		b_s3     <= bs_s2[UB_W-1:0];
		hh_s3    <= (2*HI_W)'(bs_s2[UB_W-1:LO_W]) * (2*HI_W)'(bs_s2[UB_W-1:LO_W]);
		hl_s3    <= (HI_W+LO_W)'(bs_s2[UB_W-1:LO_W]) * (HI_W+LO_W)'(bs_s2[LO_W-1:0]);
		bl2_s3   <= (2*LO_W)'(bs_s2[LO_W-1:0]) * (2*LO_W)'(bs_s2[LO_W-1:0]);
		lhs_s3   <= Q_W'(l2_s2) << (2 * DIR_FRAC_BITS);
		rr2_s3   <= Q_W'(rr_s2) << (2 * DIR_FRAC_BITS);
		cause_s3 <= cause_c3;
		plane_s3 <= (kind_s2 == KIND_PLANE);
		ua_s3    <= da_s2[DA_W-1] ? UA_W'(-da_s2) : UA_W'(da_s2);
		num_s3   <= NUM_W'(db_s2[SUM_W-1] ? UB_W'(-db_s2) : UB_W'(db_s2)) << DIR_FRAC_BITS;

		// s4: r^2 + B^2, plane overflow check
		b_s4     <= b_s3;
		rhs_s4   <= rr2_s3 + (Q_W'(hh_s3) << (2 * LO_W)) + (Q_W'(hl_s3) << (LO_W + 1))
			+ Q_W'(bl2_s3);
		lhs_s4   <= lhs_s3;
		cause_s4 <= cause_s3;
		plane_s4 <= plane_s3;
		sat_s4   <= DR_W'(num_s3) >= (DR_W'(ua_s3) << QB);
		ua_s4    <= ua_s3;
		num_s4   <= num_s3;

		// s5: discriminant
		meta_s5.plane <= plane_s4;
		meta_s5.sat   <= sat_s4;
		meta_s5.b     <= b_s4;
		meta_s5.cause <= (!plane_s4 && cause_s4 == CAUSE_HIT && diff[Q_W]) ?
			CAUSE_NO_ROOT : cause_s4;
		rad_s5        <= RD_W'(diff[Q_W-1:0]);
		dreq_s5.ua    <= ua_s4;
		dreq_s5.num   <= num_s4;
	end

	assign out_vld = vld_s5;
	assign meta    = meta_s5;
	assign rad     = rad_s5;
	assign dreq    = dreq_s5;

endmodule

>>> rtl/rspi_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on rspi_pkg; carries the item's meta data alongside.
module rspi_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  rspi_pkg::meta_t            in_meta,
	input  logic [rspi_pkg::RD_W-1:0]  rad,
	output logic                       out_vld,
	output rspi_pkg::meta_t            out_meta,
	output logic [rspi_pkg::SQ_W-1:0]  root
);
	import rspi_pkg::*;

	logic            vld_s  [SQ_W];
	meta_t           meta_s [SQ_W];
	logic [RD_W-1:0] rad_s  [SQ_W];
	logic [SQ_W+1:0] rem_s  [SQ_W];
	logic [SQ_W-1:0] root_s [SQ_W];

	for (genvar k = 0; k < SQ_W; k++) begin : g_stage
		logic            in_v;
		meta_t           in_m;
		logic [RD_W-1:0] in_rad;
		logic [SQ_W+1:0] in_rem;
		logic [SQ_W-1:0] in_root;
		logic [SQ_W+1:0] cur;
		logic [SQ_W+1:0] trial;
		logic            take;

		if (k == 0) begin : g_first
			assign in_v    = in_vld;
			assign in_m    = in_meta;
			assign in_rad  = rad;
			assign in_rem  = '0;
			assign in_root = '0;
		end else begin : g_next
			assign in_v    = vld_s[k-1];
			assign in_m    = meta_s[k-1];
			assign in_rad  = rad_s[k-1];
			assign in_rem  = rem_s[k-1];
			assign in_root = root_s[k-1];
		end

		// bring down the next two radicand bits, try (4*root + 1)
		assign cur   = {in_rem[SQ_W-1:0], in_rad[RD_W-1 -: 2]};
		assign trial = {in_root, 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			meta_s[k] <= in_m;
			rad_s[k]  <= in_rad << 2;
			rem_s[k]  <= take ? (cur - trial) : cur;
			root_s[k] <= {in_root[SQ_W-2:0], take};
		end
	end

	assign out_vld  = vld_s[SQ_W-1];
	assign out_meta = meta_s[SQ_W-1];
	assign root     = root_s[SQ_W-1];

endmodule

>>> rtl/rspi_div.sv
// Pipelined restoring divider, one quotient bit per stage, plus a delay line
// that lines its latency up with rspi_sqrt. Depends on rspi_pkg.
module rspi_div (
	input  logic                     clk,
	input  rspi_pkg::div_req_t       req,
	output logic [rspi_pkg::QB-1:0]  quo
);
	import rspi_pkg::*;

	logic [DR_W-1:0] rem_s [QB];
	logic [UA_W-1:0] ua_s  [QB];
	logic [QB-1:0]   q_s   [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic [DR_W-1:0] in_rem;
		logic [UA_W-1:0] in_ua;
		logic [QB-1:0]   in_q;
		logic [DR_W-1:0] sub;
		logic            take;

		if (k == 0) begin : g_first
			assign in_rem = DR_W'(req.num);
			assign in_ua  = req.ua;
			assign in_q   = '0;
		end else begin : g_next
			assign in_rem = rem_s[k-1];
			assign in_ua  = ua_s[k-1];
			assign in_q   = q_s[k-1];
		end

		assign sub  = DR_W'(in_ua) << (QB - 1 - k);
		assign take = (in_rem >= sub);

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? (in_rem - sub) : in_rem;
			ua_s[k]  <= in_ua;
			q_s[k]   <= {in_q[QB-2:0], take};
		end
	end

	if (PAD > 0) begin : g_pad
		logic [QB-1:0] pad_s [PAD];
		always_ff @(posedge clk) begin
			pad_s[0] <= q_s[QB-1];
			for (int i = 1; i < PAD; i++) begin
				pad_s[i] <= pad_s[i-1];
			end
		end
		assign quo = pad_s[PAD-1];
	end else begin : g_nopad
		assign quo = q_s[QB-1];
	end

endmodule

>>> rtl/rspi_back.sv
// Result stage: picks the root, truncates and saturates, settles the miss cause.
// Depends on rspi_pkg.
module rspi_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  rspi_pkg::meta_t            meta,
	input  logic [rspi_pkg::SQ_W-1:0]  root,
	input  logic [rspi_pkg::QB-1:0]    quo,
	output logic                       done,
	output logic                       hit,
	output logic [rspi_pkg::DIST_W-1:0] distance,
	output logic [2:0]                 miss_cause
);
	import rspi_pkg::*;

	logic [T_W-1:0]    t;
	logic [T_W-1:0]    tq;
	logic [DIST_W-1:0] sph_d;
	logic [DIST_W-1:0] pln_d;
	logic [DIST_W-1:0] dsel;
	cause_t            cause;

	logic              done_q;
	logic              hit_q;
	logic [DIST_W-1:0] dist_q;
	cause_t            cause_q;

	always_comb begin
		// nearer root B - sqrt(q) unless that goes negative
		t     = (T_W'(root) <= T_W'(meta.b)) ? (T_W'(meta.b) - T_W'(root))
			: (T_W'(meta.b) + T_W'(root));
		tq    = t >> DIR_FRAC_BITS;
		sph_d = (|tq[T_W-1:DIST_W]) ? '1 : tq[DIST_W-1:0];
		pln_d = meta.sat ? '1 : quo;
		dsel  = meta.plane ? pln_d : sph_d;
		priority if (meta.cause != CAUSE_HIT) begin
			cause = meta.cause;
		end else if (dsel == '0) begin
			cause = meta.plane ? CAUSE_PLANE_BEHIND : CAUSE_NONPOS;
		end else begin
			cause = CAUSE_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		hit_q   <= (cause == CAUSE_HIT);
		dist_q  <= (cause == CAUSE_HIT) ? dsel : '0;
		cause_q <= cause;
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign distance   = dist_q;
	assign miss_cause = cause_q;

endmodule

>>> rtl/ray_sphere_plane_intersect_top.sv
// Top level of the ray/sphere/plane intersection pipeline.
// Depends on rspi_pkg, rspi_front, rspi_sqrt, rspi_div and rspi_back.
//
//   channel   handshake         payload
//   request   start / busy      object_kind, offset_*, ray_dir_*, sphere_radius,
//                               plane_normal_*
//   result    done (1 cycle)    hit, distance, miss_cause
//
// One request per clock; busy is held low, a request is taken whenever start
// is high. With Q2.14 directions, a request passes through five front
// stages (products, dot sums, B^2 partials, r^2 + B^2, discriminant), then
// one stage per root bit in the square root pipe, then one result register.
// The plane divider runs beside the square root, one quotient bit per stage,
// padded to the same length. Each request yields exactly one done pulse.
// Reset clears only the valid bits; payload registers are left alone.
// The result side cannot stall, so nothing is ever held back.
module ray_sphere_plane_intersect_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  object_kind,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic signed [15:0] ray_dir_x,
	input  logic signed [15:0] ray_dir_y,
	input  logic signed [15:0] ray_dir_z,
	input  logic [30:0] sphere_radius,
	input  logic signed [15:0] plane_normal_x,
	input  logic signed [15:0] plane_normal_y,
	input  logic signed [15:0] plane_normal_z,
	output logic        done,
	output logic        hit,
	output logic [31:0] distance,
	output logic [2:0]  miss_cause
);
	import rspi_pkg::*;

	logic signed [CRD_W-1:0] lv [3];
	logic signed [DIR_W-1:0] dv [3];
	logic signed [DIR_W-1:0] nv [3];

	logic            fr_vld;
	meta_t           fr_meta;
	logic [RD_W-1:0] fr_rad;
	div_req_t        fr_dreq;

	logic            sq_vld;
	meta_t           sq_meta;
	logic [SQ_W-1:0] sq_root;
	logic [QB-1:0]   dv_quo;

	// fully pipelined, never refuses a request
	assign busy = 1'b0;

	assign lv[0] = offset_x;
	assign lv[1] = offset_y;
	assign lv[2] = offset_z;
	assign dv[0] = ray_dir_x;
	assign dv[1] = ray_dir_y;
	assign dv[2] = ray_dir_z;
	assign nv[0] = plane_normal_x;
	assign nv[1] = plane_normal_y;
	assign nv[2] = plane_normal_z;

	rspi_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.kind    (object_kind),
		.lv      (lv),
		.dv      (dv),
		.nv      (nv),
		.radius  (sphere_radius),
		.out_vld (fr_vld),
		.meta    (fr_meta),
		.rad     (fr_rad),
		.dreq    (fr_dreq)
	);

	// sphere: floor sqrt of the discriminant term
	rspi_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fr_vld),
		.in_meta  (fr_meta),
		.rad      (fr_rad),
		.out_vld  (sq_vld),
		.out_meta (sq_meta),
		.root     (sq_root)
	);

	// plane: (|L.n| << frac) / |d.n|, same latency as the sqrt pipe
	rspi_div u_div (
		.clk (clk),
		.req (fr_dreq),
		.quo (dv_quo)
	);

	rspi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (sq_vld),
		.meta       (sq_meta),
		.root       (sq_root),
		.quo        (dv_quo),
		.done       (done),
		.hit        (hit),
		.distance   (distance),
		.miss_cause (miss_cause)
	);

endmodule

>>> verif/ray_sphere_plane_intersect_top_tb.sv
// Self-checking testbench for ray_sphere_plane_intersect_top: sphere and plane hit tests.
// Depends on rspi_pkg and the RTL top level; predicts each request's answer in exact math.
module ray_sphere_plane_intersect_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rspi_pkg::*;

	localparam int DFB = DIR_FRAC_BITS;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [1:0]         kind;
		logic signed [31:0] lx, ly, lz;
		logic signed [15:0] dx, dy, dz;
		logic [30:0]        rad;
		logic signed [15:0] nx, ny, nz;
	} ray_req_t;

	typedef struct {
		logic        hit;
		logic [31:0] dist_v;
		cause_t      cause;
	} hit_rsp_t;

	logic clk, arst_n, start, busy, done, hit;
	logic [1:0] object_kind;
	logic signed [31:0] offset_x, offset_y, offset_z;
	logic signed [15:0] ray_dir_x, ray_dir_y, ray_dir_z;
	logic [30:0] sphere_radius;
	logic signed [15:0] plane_normal_x, plane_normal_y, plane_normal_z;
	logic [31:0] distance;
	logic [2:0] miss_cause;

	ray_req_t pending_reqs[$];
	hit_rsp_t expected_hits[$];
	int mismatches = 0;
	int idle_cycles = 0;

	ray_sphere_plane_intersect_top dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic hit_rsp_t make_rsp(logic [31:0] d, cause_t c);
		hit_rsp_t r;
		r.hit = (c == CAUSE_HIT);
		r.dist_v = (c == CAUSE_HIT) ? d : 32'd0;
		r.cause = c;
		return r;
	endfunction

	// floor square root of a wide unsigned value, bit by bit
	function automatic logic [127:0] isqrt(logic [255:0] x);
		logic [127:0] res;
		logic [127:0] c;
		res = '0;
		for (int b = 127; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if ({128'd0, c} * {128'd0, c} <= x)
				res = c;
		end
		return res;
	endfunction

	// exact intersection prediction; all math in wide signed vectors
	function automatic hit_rsp_t predict_hit(ray_req_t q);
		logic signed [255:0] b, l2, rr, lhs, rhs, t, da, db, num, ua, quo;
		logic [127:0] sq;
		if (q.kind == KIND_SPHERE) begin
			b = 256'(q.lx) * q.dx + 256'(q.ly) * q.dy + 256'(q.lz) * q.dz;
			if (b < 0)
				return make_rsp(0, CAUSE_BEHIND);
			l2 = 256'(q.lx) * q.lx + 256'(q.ly) * q.ly + 256'(q.lz) * q.lz;
			rr = $signed({225'd0, q.rad}) * $signed({225'd0, q.rad});
			lhs = l2 <<< (2 * DFB);
			rhs = (rr <<< (2 * DFB)) + b * b;
			if (lhs > rhs)
				return make_rsp(0, CAUSE_NO_ROOT);
			sq = isqrt(256'(rhs - lhs));
			t = ($signed({128'd0, sq}) <= b) ? b - $signed({128'd0, sq})
				: b + $signed({128'd0, sq});
			t = t >>> DFB;
			if (t > 256'sh0FFFFFFFF)
				t = 256'sh0FFFFFFFF;
			if (t == 0)
				return make_rsp(0, CAUSE_NONPOS);
			return make_rsp(t[31:0], CAUSE_HIT);
		end
		if (q.kind == KIND_PLANE) begin
			da = 256'(q.dx) * q.nx + 256'(q.dy) * q.ny + 256'(q.dz) * q.nz;
			db = 256'(q.lx) * q.nx + 256'(q.ly) * q.ny + 256'(q.lz) * q.nz;
			if (da == 0)
				return make_rsp(0, CAUSE_PARALLEL);
			if (db == 0 || ((da < 0) != (db < 0)))
				return make_rsp(0, CAUSE_PLANE_BEHIND);
			ua = (da < 0) ? -da : da;
			num = ((db < 0) ? -db : db) <<< DFB;
			quo = num / ua;
			if (quo > 256'sh0FFFFFFFF)
				quo = 256'sh0FFFFFFFF;
			if (quo == 0)
				return make_rsp(0, CAUSE_PLANE_BEHIND);
			return make_rsp(quo[31:0], CAUSE_HIT);
		end
		return make_rsp(0, CAUSE_KIND);
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// set at the rising edge when a request was taken
	bit took = 0;

	// driver: presents queued requests at the falling edge
	int gap_left = 0;
	bit bursty = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// hold the request until it is taken
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending_reqs.size() > 0) begin
			ray_req_t q;
			q = pending_reqs.pop_front();
			object_kind <= q.kind;
			offset_x <= q.lx; offset_y <= q.ly; offset_z <= q.lz;
			ray_dir_x <= q.dx; ray_dir_y <= q.dy; ray_dir_z <= q.dz;
			sphere_radius <= q.rad;
			plane_normal_x <= q.nx; plane_normal_y <= q.ny; plane_normal_z <= q.nz;
			start <= 1'b1;
			if ($urandom_range(199) == 0)
				bursty <= !bursty;
			gap_left <= bursty ? 0 : pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// acceptance and result check at the rising edge
	always @(posedge clk) begin
		ray_req_t q;
		hit_rsp_t e;
		took <= start && !busy;
		if (arst_n && start && !busy) begin
			q.kind = object_kind;
			q.lx = offset_x; q.ly = offset_y; q.lz = offset_z;
			q.dx = ray_dir_x; q.dy = ray_dir_y; q.dz = ray_dir_z;
			q.rad = sphere_radius;
			q.nx = plane_normal_x; q.ny = plane_normal_y; q.nz = plane_normal_z;
			expected_hits.push_back(predict_hit(q));
		end
		if (arst_n && done) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: hit=%0b dist=%h cause=%0d",
						hit, distance, miss_cause);
			end else begin
				e = expected_hits.pop_front();
				if (hit !== e.hit || distance !== e.dist_v || miss_cause !== e.cause) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0b dist=%h cause=%0d, got hit=%0b dist=%h cause=%0d",
							e.hit, e.dist_v, e.cause, hit, distance, miss_cause);
				end
			end
		end
		// watchdog: cycles with neither a request nor a result taken
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_unit();
		int p;
		p = $urandom_range(9);
		if (p == 0) return 16'($urandom);
		if (p == 1) return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		return 16'($signed($urandom_range(32767)) - 16384) ;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		int p;
		p = $urandom_range(9);
		if (p < 2) return 32'($urandom);
		// mostly small scenes so spheres and planes are often hit
		return 32'($signed($urandom_range(32'h00400000)) - 32'sh00200000);
	endfunction

	task automatic add_req(logic [1:0] k, logic signed [31:0] x, y, z,
			logic signed [15:0] a, b, c, logic [30:0] r,
			logic signed [15:0] u, v, w);
		ray_req_t q;
		q.kind = k; q.lx = x; q.ly = y; q.lz = z;
		q.dx = a; q.dy = b; q.dz = c; q.rad = r;
		q.nx = u; q.ny = v; q.nz = w;
		pending_reqs.push_back(q);
	endtask

	initial begin
		ray_req_t q;
		arst_n = 1'b0;
		start = 1'b0;
		object_kind = '0;
		offset_x = '0; offset_y = '0; offset_z = '0;
		ray_dir_x = '0; ray_dir_y = '0; ray_dir_z = '0;
		sphere_radius = '0;
		plane_normal_x = '0; plane_normal_y = '0; plane_normal_z = '0;

		// sphere straight ahead: hit
		add_req(KIND_SPHERE, 0, 0, 32'sh000A0000, 0, 0, 16'sh4000, 31'h00020000, 0, 0, 0);
		// sphere behind the origin
		add_req(KIND_SPHERE, 0, 0, -32'sh000A0000, 0, 0, 16'sh4000, 31'h00020000, 0, 0, 0);
		// ray passes beside: no roots
		add_req(KIND_SPHERE, 32'sh00050000, 0, 32'sh000A0000, 0, 0, 16'sh4000,
			31'h00010000, 0, 0, 0);
		// exact tangent
		add_req(KIND_SPHERE, 32'sh00020000, 0, 32'sh000A0000, 0, 0, 16'sh4000,
			31'h00020000, 0, 0, 0);
		// origin inside sphere: far root
		add_req(KIND_SPHERE, 0, 0, 32'sh00010000, 0, 0, 16'sh4000, 31'h00050000, 0, 0, 0);
		// everything zero: zero distance
		add_req(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// extremes: largest-magnitude inputs
		add_req(KIND_SPHERE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 31'h7FFFFFFF, 0, 0, 0);
		add_req(KIND_SPHERE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			16'sh8000, 16'sh8000, 16'sh8000, 31'h7FFFFFFF, 16'sh7FFF, 16'sh8000, 0);
		// plane ahead: hit
		add_req(KIND_PLANE, 0, 0, 32'sh000A0000, 0, 0, 16'sh4000, 0, 0, 0, 16'shC000);
		// plane parallel
		add_req(KIND_PLANE, 0, 0, 32'sh000A0000, 16'sh4000, 0, 0, 0, 0, 0, 16'sh4000);
		// plane behind, and lying on the plane
		add_req(KIND_PLANE, 0, 0, -32'sh000A0000, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000);
		add_req(KIND_PLANE, 0, 0, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000);
		// tiny quotient truncates to zero
		add_req(KIND_PLANE, 0, 0, 1, 0, 0, 16'sh7FFF, 0, 0, 0, 16'sh0001);
		// huge quotient saturates; then all-extreme inputs
		add_req(KIND_PLANE, 0, 0, 32'sh7FFFFFFF, 0, 0, 16'sh0001, 0, 0, 0, 16'sh7FFF);
		add_req(KIND_PLANE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			16'sh8000, 16'sh8000, 16'sh8000, 31'h7FFFFFFF, 16'sh8000, 16'sh8000, 16'sh8000);
		// unknown kinds
		add_req(2'd2, 0, 0, 32'sh000A0000, 0, 0, 16'sh4000, 31'h00020000, 0, 0, 0);
		add_req(2'd3, -1, -1, -1, -1, -1, -1, 31'h7FFFFFFF, -1, -1, -1);

		for (int i = 0; i < 1000; i++) begin
			q.kind = ($urandom_range(19) == 0) ? 2'($urandom_range(3, 2))
				: 2'($urandom_range(1));
			q.lx = rand_coord(); q.ly = rand_coord(); q.lz = rand_coord();
			q.dx = rand_unit(); q.dy = rand_unit(); q.dz = rand_unit();
			q.rad = ($urandom_range(9) == 0) ? 31'($urandom)
				: 31'($urandom_range(32'h00300000));
			q.nx = rand_unit(); q.ny = rand_unit(); q.nz = rand_unit();
			pending_reqs.push_back(q);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (start) @(posedge clk);
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (70) @(posedge clk);
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
